@@ rtl/stree_pkg.sv @@
package stree_pkg;

	localparam int SUM_W = 42;
	localparam int VAL_W = 32;
	localparam int POS_W = 11;

	localparam logic MODE_SET   = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	typedef logic [POS_W-1:0]        pos_t;
	typedef logic signed [VAL_W-1:0] val_t;
	typedef logic signed [SUM_W-1:0] sum_t;

endpackage

@@ rtl/stree_if.sv @@
interface stree_req_if;
	import stree_pkg::*;

	logic valid;
	logic ready;
	logic mode;
	pos_t position;
	val_t value;
	pos_t range_low;
	pos_t range_high;

	modport source (output valid, mode, position, value, range_low, range_high, input ready);
	modport sink   (input valid, mode, position, value, range_low, range_high, output ready);
endinterface

interface stree_rsp_if;
	import stree_pkg::*;

	logic valid;
	logic ready;
	sum_t range_sum;

	modport source (output valid, range_sum, input ready);
	modport sink   (input valid, range_sum, output ready);
endinterface

@@ rtl/segment_tree_range_sum.sv @@
// Set: accepted when idle, then ST_SET writes one tree level at a time from leaf to root;
//   a position outside the tree is accepted and dropped.
// Query: ST_QRY handles one tree level at a time, two node reads per cycle, then ST_FIN
//   waits until the result register is free and loads the result.
// Items are handled one at a time: a new one is taken only back in ST_IDLE.
// Reset (arst_n low) clears control; a clearing pass then zeroes 2*LEAVES nodes.
module segment_tree_range_sum #(
	parameter int LEAVES = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	stree_req_if.sink          req,
	stree_rsp_if.source        rsp
);
	import stree_pkg::*;

	localparam int DEPTH = 2 * LEAVES;
	localparam int IW    = $clog2(DEPTH);
	localparam int RW    = IW + 1;
	localparam int CW    = (RW > POS_W + 1) ? RW : POS_W + 1;

	typedef enum logic [2:0] {
		ST_CLR,
		ST_IDLE,
		ST_SET,
		ST_QRY,
		ST_FIN
	} state_t;

	state_t          state_q;
	logic [IW-1:0]   clr_q;
	logic [IW-1:0]   node_q;
	logic            first_q;
	sum_t            cur_q;
	logic [RW-1:0]   l_q;
	logic [RW-1:0]   r_q;
	logic            fl_s1;
	logic            fr_s1;
	sum_t            acc_l_q;
	sum_t            acc_r_q;
	logic            rsp_valid_q;
	sum_t            rsp_sum_q;

	sum_t            mem [DEPTH];
	sum_t            rd0_s1;
	sum_t            rd1_s1;
	logic            we;
	logic [IW-1:0]   waddr;
	sum_t            wdata;
	logic [IW-1:0]   ra0;
	logic [IW-1:0]   ra1;

	logic [CW-1:0]   pos_c;
	logic [CW-1:0]   lo_c;
	logic [CW-1:0]   hi_c;
	logic [CW-1:0]   leaf_c;
	logic [CW-1:0]   l_init_c;
	logic [CW-1:0]   r_init_c;
	logic            set_ok;
	logic            accept;
	logic            fin_load;
	sum_t            set_sum;

	assign req.ready     = (state_q == ST_IDLE);
	assign accept        = req.valid && req.ready;
	assign rsp.valid     = rsp_valid_q;
	assign rsp.range_sum = rsp_sum_q;
	assign fin_load      = (state_q == ST_FIN) && (!rsp_valid_q || rsp.ready);

	always_comb begin
		pos_c    = CW'(req.position);
		set_ok   = (pos_c != '0) && (pos_c <= CW'(LEAVES));
		leaf_c   = CW'(LEAVES) + pos_c - CW'(1);
		// clip the range to 1..LEAVES
		lo_c     = (req.range_low == '0) ? CW'(1) : CW'(req.range_low);
		hi_c     = (CW'(req.range_high) > CW'(LEAVES)) ? CW'(LEAVES) : CW'(req.range_high);
		l_init_c = CW'(LEAVES) + lo_c - CW'(1);
		r_init_c = CW'(LEAVES) + hi_c;
		set_sum  = first_q ? cur_q : cur_q + rd0_s1;
	end

	always_comb begin
		we    = 1'b0;
		waddr = node_q;
		wdata = set_sum;
		ra0   = l_q[IW-1:0];
		ra1   = {r_q[IW-1:1], 1'b0};
		case (state_q)
			ST_CLR: begin
				we    = 1'b1;
				waddr = clr_q;
				wdata = '0;
			end
			ST_SET: begin
				we  = 1'b1;
				ra0 = node_q ^ IW'(1);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd0_s1 <= mem[ra0];
		rd1_s1 <= mem[ra1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			clr_q       <= '0;
			node_q      <= '0;
			first_q     <= 1'b0;
			cur_q       <= '0;
			l_q         <= '0;
			r_q         <= '0;
			fl_s1       <= 1'b0;
			fr_s1       <= 1'b0;
			acc_l_q     <= '0;
			acc_r_q     <= '0;
			rsp_valid_q <= 1'b0;
			rsp_sum_q   <= '0;
		end else begin
			fl_s1       <= (state_q == ST_QRY) && (l_q < r_q) && l_q[0];
			fr_s1       <= (state_q == ST_QRY) && (l_q < r_q) && r_q[0];
			rsp_valid_q <= fin_load || (rsp_valid_q && !rsp.ready);
			if (fl_s1) begin
				acc_l_q <= acc_l_q + rd0_s1;
			end
			if (fr_s1) begin
				acc_r_q <= acc_r_q + rd1_s1;
			end
			case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + IW'(1);
					if (clr_q == IW'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						if (req.mode == MODE_QUERY) begin
							acc_l_q <= '0;
							acc_r_q <= '0;
							l_q     <= l_init_c[RW-1:0];
							r_q     <= r_init_c[RW-1:0];
							state_q <= (lo_c > hi_c) ? ST_FIN : ST_QRY;
						end else if (set_ok) begin
							node_q  <= leaf_c[IW-1:0];
							cur_q   <= SUM_W'(req.value);
							first_q <= 1'b1;
							state_q <= ST_SET;
						end
					end
				end
				ST_SET: begin
					// write this node, fetch its sibling, climb one level
					cur_q   <= set_sum;
					first_q <= 1'b0;
					node_q  <= node_q >> 1;
					if (node_q == IW'(1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_QRY: begin
					if (l_q < r_q) begin
						l_q <= (l_q + RW'(l_q[0])) >> 1;
						r_q <= (r_q - RW'(r_q[0])) >> 1;
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					// hold until the result register is free
					if (fin_load) begin
						rsp_sum_q <= acc_l_q + acc_r_q;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

@@ rtl/stree_chk.sv @@
module stree_chk (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	input  logic            req_ready,
	input  logic            req_mode,
	input  logic            rsp_valid,
	input  logic            rsp_ready,
	input  stree_pkg::sum_t rsp_range_sum
);
	import stree_pkg::*;

	logic       q_acc;
	logic       r_xfer;
	logic [1:0] pend_q;

	assign q_acc  = req_valid && req_ready && (req_mode == MODE_QUERY);
	assign r_xfer = rsp_valid && rsp_ready;

	// count queries whose result has not yet been transferred
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 2'(q_acc) - 2'(r_xfer);
		end
	end

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_range_sum))
		else $error("result dropped or changed while stalled");

	a_rsp_owed: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> pend_q != 2'd0)
		else $error("result without a pending query");

	a_pend_max: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != 2'd3)
		else $error("too many queries outstanding");

	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		q_acc |=> !req_ready)
		else $error("query did not occupy the block");

endmodule

bind segment_tree_range_sum stree_chk u_stree_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.req_mode      (req.mode),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.rsp_range_sum (rsp.range_sum)
);

@@ sim/tb_top.sv @@
module tb_top;
	import stree_pkg::*;

	localparam int LEAVES = 1024;
	localparam int CLK_PERIOD = 12;
	localparam int TIMEOUT_CYCLES = 500000;
	localparam int RANDOM_ITEMS = 1650;

	typedef struct {
		logic mode;
		pos_t position;
		val_t value;
		pos_t range_low;
		pos_t range_high;
	} tree_op_t;

	class range_sum_scoreboard;
		sum_t tree_sums[2*LEAVES];
		sum_t sums_due[$];
		int sets_done;
		int sets_dropped;
		int queries_done;
		int queries_empty;
		int sums_checked;
		int mismatches;

		function new();
			foreach (tree_sums[k]) tree_sums[k] = '0;
			sets_done = 0;
			sets_dropped = 0;
			queries_done = 0;
			queries_empty = 0;
			sums_checked = 0;
			mismatches = 0;
		endfunction

		function void write_leaf(int unsigned slot, val_t v);
			int unsigned k;
			k = LEAVES + slot - 1;
			tree_sums[k] = SUM_W'(v);
			// refresh every ancestor up to the root
			while (k > 1) begin
				k = k >> 1;
				tree_sums[k] = tree_sums[2*k] + tree_sums[2*k+1];
			end
		endfunction

		function sum_t span_total(int unsigned lo, int unsigned hi);
			sum_t acc;
			int unsigned l;
			int unsigned r;
			acc = '0;
			l = LEAVES + lo - 1;
			r = LEAVES + hi;
			while (l < r) begin
				if ((l & 1) != 0) begin
					acc = acc + tree_sums[l];
					l++;
				end
				if ((r & 1) != 0) begin
					r--;
					acc = acc + tree_sums[r];
				end
				l = l >> 1;
				r = r >> 1;
			end
			return acc;
		endfunction

		function void note_request(logic mode, pos_t slot, val_t v, pos_t lo_in, pos_t hi_in);
			int unsigned lo;
			int unsigned hi;
			if (mode == MODE_SET) begin
				if (slot >= 1 && slot <= LEAVES) begin
					write_leaf(32'(slot), v);
					sets_done++;
				end else begin
					sets_dropped++;
				end
			end else begin
				// clip to the tree, then an inverted span sums to zero
				lo = (lo_in < 1) ? 1 : 32'(lo_in);
				hi = (hi_in > LEAVES) ? LEAVES : 32'(hi_in);
				queries_done++;
				if (lo > hi) begin
					queries_empty++;
					sums_due.push_back('0);
				end else begin
					sums_due.push_back(span_total(lo, hi));
				end
			end
		endfunction

		task report_mismatch(string msg);
			mismatches++;
			$display("mismatch %0d at %0t: %s", mismatches, $time, msg);
		endtask

		task check_sum(sum_t got);
			sum_t want;
			if (sums_due.size() == 0) begin
				report_mismatch($sformatf("range_sum %0d with no query outstanding", got));
			end else begin
				want = sums_due.pop_front();
				sums_checked++;
				if (got !== want)
					report_mismatch($sformatf("range_sum %0d, expected %0d", got, want));
			end
		endtask

		task check_drained();
			if (sums_due.size() != 0)
				report_mismatch($sformatf("%0d sums never returned", sums_due.size()));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;

	stree_req_if req_if ();
	stree_rsp_if rsp_if ();

	segment_tree_range_sum #(.LEAVES(LEAVES)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if.sink),
		.rsp    (rsp_if.source)
	);

	range_sum_scoreboard sb = new();

	int hold_req = 0;
	int burst_left = 1;

	always #(CLK_PERIOD/2) clk = ~clk;

	initial begin
		#(CLK_PERIOD * TIMEOUT_CYCLES);
		$display("CHECK FAILED");
		$finish;
	end

	// check returned sums before noting the transfer of the same edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_if.valid && rsp_if.ready)
				sb.check_sum(rsp_if.range_sum);
			if (req_if.valid && req_if.ready)
				sb.note_request(req_if.mode, req_if.position, req_if.value,
					req_if.range_low, req_if.range_high);
		end
	end

	// receiver: rotating stall styles, plus long hold-offs on request
	initial begin
		int unsigned hold_left;
		int unsigned cyc;
		logic take;
		hold_left = 0;
		cyc = 0;
		rsp_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			cyc++;
			if (hold_req != 0) begin
				hold_left = hold_req;
				hold_req = 0;
			end
			if (hold_left != 0) begin
				hold_left--;
				take = 1'b0;
			end else begin
				case ((cyc / 300) % 4)
					0: take = 1'b1;
					1: take = ($urandom_range(0, 3) != 0);
					2: take = ((cyc % 5) >= 2);
					default: take = ($urandom_range(0, 3) == 0);
				endcase
			end
			rsp_if.ready <= take;
		end
	end

	function automatic tree_op_t make_set(int slot, val_t v);
		tree_op_t op;
		op.mode = MODE_SET;
		op.position = POS_W'(slot);
		op.value = v;
		op.range_low = POS_W'($urandom_range(0, 2047));
		op.range_high = POS_W'($urandom_range(0, 2047));
		return op;
	endfunction

	function automatic tree_op_t make_query(int lo, int hi);
		tree_op_t op;
		op.mode = MODE_QUERY;
		op.position = POS_W'($urandom_range(0, 2047));
		op.value = $urandom;
		op.range_low = POS_W'(lo);
		op.range_high = POS_W'(hi);
		return op;
	endfunction

	function automatic val_t pick_value();
		case ($urandom_range(0, 5))
			0: return 32'sh7FFF_FFFF;
			1: return 32'sh8000_0000;
			2: return $urandom_range(0, 200) - 100;
			default: return $urandom;
		endcase
	endfunction

	// offer one item, hold it until the transfer, then maybe leave a gap
	task automatic send_op(tree_op_t op);
		req_if.valid <= 1'b1;
		req_if.mode <= op.mode;
		req_if.position <= op.position;
		req_if.value <= op.value;
		req_if.range_low <= op.range_low;
		req_if.range_high <= op.range_high;
		do @(posedge clk); while (!req_if.ready);
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 40);
			if ($urandom_range(0, 3) != 0) begin
				req_if.valid <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
	endtask

	task automatic wait_all_returned();
		req_if.valid <= 1'b0;
		do @(posedge clk); while (sb.sums_due.size() != 0);
	endtask

	task automatic send_random_query();
		int lo;
		int span;
		case ($urandom_range(0, 5))
			0: begin
				lo = $urandom_range(1, LEAVES);
				span = $urandom_range(0, LEAVES - lo);
				send_op(make_query(lo, lo + span));
			end
			1: begin
				lo = $urandom_range(1, LEAVES);
				send_op(make_query(lo, lo));
			end
			2: send_op(make_query(1, LEAVES));
			3: send_op(make_query($urandom_range(0, 2047), $urandom_range(0, 2047)));
			4: begin
				lo = $urandom_range(2, 2047);
				send_op(make_query(lo, $urandom_range(0, lo - 1)));
			end
			default: send_op(make_query($urandom_range(0, 4), $urandom_range(1019, 1030)));
		endcase
	endtask

	initial begin
		int counted;
		int hold_at;
		int pick;
		int run_len;
		int base;
		int slot;
		val_t v;

		arst_n <= 1'b0;
		req_if.valid <= 1'b0;
		req_if.mode <= MODE_SET;
		req_if.position <= '0;
		req_if.value <= '0;
		req_if.range_low <= '0;
		req_if.range_high <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty tree, field extremes, sets outside the tree, clipped and empty spans
		send_op(make_query(1, LEAVES));
		send_op(make_set(1, 32'sh7FFF_FFFF));
		send_op(make_set(LEAVES, 32'sh8000_0000));
		send_op(make_set(0, 12345));
		send_op(make_set(LEAVES + 1, -1));
		send_op(make_set(2047, 32'sh7FFF_FFFF));
		send_op(make_set(512, -1));
		send_op(make_set(513, 32'sh5555_5555));
		send_op(make_set(2, 32'shAAAA_AAAA));
		send_op(make_query(1, LEAVES));
		send_op(make_query(0, 2047));
		send_op(make_query(1, 1));
		send_op(make_query(LEAVES, LEAVES));
		send_op(make_query(0, 0));
		send_op(make_query(2047, 2047));
		send_op(make_query(5, 4));
		send_op(make_query(LEAVES + 1, 2047));
		send_op(make_query(512, 513));
		send_op(make_query(2, LEAVES - 1));
		send_op(make_set(1, 0));
		send_op(make_query(0, 1));
		send_op(make_query(LEAVES - 1, LEAVES + 6));

		counted = 0;
		hold_at = 0;
		while (counted < RANDOM_ITEMS) begin
			// drain, then stall the receiver while items keep coming
			if (counted >= hold_at) begin
				wait_all_returned();
				hold_req = $urandom_range(250, 350);
				send_op(make_query(1, LEAVES));
				counted++;
				hold_at += 700;
			end
			pick = $urandom_range(0, 99);
			if (pick < 5) begin
				run_len = $urandom_range(8, 64);
				base = $urandom_range(1, LEAVES - run_len + 1);
				v = pick_value();
				for (int i = 0; i < run_len; i++)
					send_op(make_set(base + i, v));
				send_op(make_query(base, base + run_len - 1));
				counted += run_len + 1;
			end else if (pick < 15) begin
				slot = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(LEAVES + 1, 2047);
				send_op(make_set(slot, $urandom));
				counted++;
			end else if (pick < 55) begin
				if ($urandom_range(0, 9) == 0)
					slot = $urandom_range(0, 1) ? 1 : LEAVES;
				else
					slot = $urandom_range(1, LEAVES);
				send_op(make_set(slot, pick_value()));
				counted++;
			end else begin
				send_random_query();
				counted++;
			end
		end

		wait_all_returned();
		repeat (40) @(posedge clk);
		sb.check_drained();
		$display("%0d sets (%0d outside the tree), %0d queries (%0d empty after clipping)",
			sb.sets_done + sb.sets_dropped, sb.sets_dropped, sb.queries_done, sb.queries_empty);
		$display("%0d range sums compared, %0d mismatches", sb.sums_checked, sb.mismatches);
		if (sb.mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
